// ===== sv/dr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dr_pkg
// Types and constants shared by the detector ray direction block.
// ----------------------------------------------------------------------------
package dr_pkg;

    localparam int MAX_SIDE   = 4096;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 18;
    localparam int MID_DEPTH  = 4;

    localparam logic [2:0] CFG_COLS    = 3'd0;
    localparam logic [2:0] CFG_ROWS    = 3'd1;
    localparam logic [2:0] CFG_PITCH_X = 3'd2;
    localparam logic [2:0] CFG_PITCH_Y = 3'd3;
    localparam logic [2:0] CFG_REL_X   = 3'd4;
    localparam logic [2:0] CFG_REL_Y   = 3'd5;
    localparam logic [2:0] CFG_REL_Z   = 3'd6;
    localparam logic [2:0] CFG_MODE    = 3'd7;

    localparam logic [1:0] MODE_CONE = 2'd1;
    localparam logic [1:0] MODE_VEC  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic signed [15:0] RAY_ONE = 16'sd32767;

    typedef struct packed {
        logic        [11:0] pixel_col;
        logic        [11:0] pixel_row;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] ray_x;
        logic signed [15:0] ray_y;
        logic signed [15:0] ray_z;
        logic        [1:0]  status;
    } t_out;

    typedef struct packed {
        logic        [12:0] cols;
        logic        [12:0] rows;
        logic        [23:0] pitch_x;
        logic        [23:0] pitch_y;
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_z;
        logic        [1:0]  beam_mode;
    } t_cfg;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [1:0]       status;
        logic             par;
        logic [63:0]      sum;
    } t_mid;

endpackage

// ===== sv/detector_ray_direction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_ray_direction
// Unit ray direction for one detector pixel in parallel, cone or vector beam.
// ----------------------------------------------------------------------------
// The block takes one item per clock while o_full is low and gives one result
// per item, in order. On the way the item passes four front stages, the
// middle queue, the square root entry register and 32 square root stages (one
// root bit per stage), the division entry register and 18 division stages
// (one quotient bit per stage, three lanes), and the result queue. A full
// result queue stalls the back part; a full middle queue stalls the front and
// raises o_full. Write configuration only while no item is in flight.
// ----------------------------------------------------------------------------
module detector_ray_direction (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  dr_pkg::t_in   i_item,
    output logic          o_empty,
    input  logic          i_pop,
    output dr_pkg::t_out  o_result,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    dr_pkg::t_cfg r_cfg;
    dr_pkg::t_mid mid_in, mid_out;
    logic         mid_push, mid_full, mid_pop, mid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cols      <= 13'd1;
            r_cfg.rows      <= 13'd1;
            r_cfg.pitch_x   <= 24'd65536;
            r_cfg.pitch_y   <= 24'd65536;
            r_cfg.rel_x     <= '0;
            r_cfg.rel_y     <= '0;
            r_cfg.rel_z     <= 32'sd65536;
            r_cfg.beam_mode <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dr_pkg::CFG_COLS:    r_cfg.cols      <= i_cfg_data[12:0];
                dr_pkg::CFG_ROWS:    r_cfg.rows      <= i_cfg_data[12:0];
                dr_pkg::CFG_PITCH_X: r_cfg.pitch_x   <= i_cfg_data[23:0];
                dr_pkg::CFG_PITCH_Y: r_cfg.pitch_y   <= i_cfg_data[23:0];
                dr_pkg::CFG_REL_X:   r_cfg.rel_x     <= i_cfg_data;
                dr_pkg::CFG_REL_Y:   r_cfg.rel_y     <= i_cfg_data;
                dr_pkg::CFG_REL_Z:   r_cfg.rel_z     <= i_cfg_data;
                dr_pkg::CFG_MODE:    r_cfg.beam_mode <= i_cfg_data[1:0];
                default:             r_cfg.beam_mode <= r_cfg.beam_mode;
            endcase
        end
    end

    dr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_item     (i_item),
        .i_mid_full (mid_full),
        .o_mid_push (mid_push),
        .o_mid      (mid_in)
    );

    dr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_valid (mid_valid),
        .o_data  (mid_out)
    );

    dr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid_out),
        .o_mid_pop   (mid_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result)
    );

endmodule

// ===== sv/dr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dr_front
// Accepts items, classifies them, builds the direction vector, aligns its
// magnitudes and squares them.
// ----------------------------------------------------------------------------
module dr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dr_pkg::t_cfg  i_cfg,
    input  logic          i_push,
    output logic          o_full,
    input  dr_pkg::t_in   i_item,
    input  logic          i_mid_full,
    output logic          o_mid_push,
    output dr_pkg::t_mid  o_mid
);

    typedef struct packed {
        logic                    bad;
        logic [1:0]              mode;
        logic signed [39:0]      dx;
        logic signed [39:0]      dy;
        logic [2:0][31:0]        vec;
    } t_f1;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [1:0]       status;
        logic             par;
    } t_f2;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [1:0]       status;
        logic             par;
        logic [2:0][63:0] sq;
    } t_f4;

    logic       en;
    logic       accept;
    logic [3:0] r_v;
    t_f1        r_f1, n_f1;
    t_f2        r_f2, n_f2;
    t_f2        r_f3, n_f3;
    t_f4        r_f4, n_f4;

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] res;
        if (v > 41'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -41'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

    assign en         = !i_mid_full;
    assign o_full     = !en;
    assign accept     = i_push && en;
    assign o_mid_push = en && r_v[3];

    always_comb begin
        logic signed [14:0] kx;
        logic signed [14:0] ky;
        kx = 15'({2'b0, i_item.pixel_col, 1'b0}) - 15'({2'b0, i_cfg.cols}) + 15'sd1;
        ky = 15'({2'b0, i_item.pixel_row, 1'b0}) - 15'({2'b0, i_cfg.rows}) + 15'sd1;
        n_f1.bad  = (i_cfg.cols == 13'd0) || (i_cfg.rows == 13'd0) ||
                    (i_cfg.cols > 13'(dr_pkg::MAX_SIDE)) ||
                    (i_cfg.rows > 13'(dr_pkg::MAX_SIDE)) ||
                    ({1'b0, i_item.pixel_col} >= i_cfg.cols) ||
                    ({1'b0, i_item.pixel_row} >= i_cfg.rows);
        n_f1.mode = i_cfg.beam_mode;
        n_f1.dx   = 40'(signed'({1'b0, i_cfg.pitch_x})) * 40'(kx);
        n_f1.dy   = 40'(signed'({1'b0, i_cfg.pitch_y})) * 40'(ky);
        n_f1.vec  = {i_item.vec_z, i_item.vec_y, i_item.vec_x};
    end

    always_comb begin
        logic signed [31:0] c [3];
        c[0] = sat32(41'(i_cfg.rel_x) + 41'(r_f1.dx >>> 1));
        c[1] = sat32(41'(i_cfg.rel_y) + 41'(r_f1.dy >>> 1));
        c[2] = i_cfg.rel_z;
        if (r_f1.mode == dr_pkg::MODE_VEC) begin
            c[0] = r_f1.vec[0];
            c[1] = r_f1.vec[1];
            c[2] = r_f1.vec[2];
        end
        for (int i = 0; i < 3; i++) begin
            n_f2.neg[i] = c[i][31];
            n_f2.mag[i] = c[i][31] ? 32'(-c[i]) : 32'(c[i]);
        end
        n_f2.par    = 1'b0;
        n_f2.status = dr_pkg::ST_OK;
        if (r_f1.bad) begin
            n_f2.status = dr_pkg::ST_RANGE;
        end else if (r_f1.mode != dr_pkg::MODE_CONE && r_f1.mode != dr_pkg::MODE_VEC) begin
            n_f2.par = 1'b1;
        end
    end

    always_comb begin
        logic [31:0] mx;
        logic [4:0]  msb;
        logic [4:0]  sh;
        mx = r_f2.mag[0];
        if (r_f2.mag[1] > mx) mx = r_f2.mag[1];
        if (r_f2.mag[2] > mx) mx = r_f2.mag[2];
        msb = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (mx[i]) msb = 5'(i);
        end
        sh = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
        n_f3 = r_f2;
        for (int i = 0; i < 3; i++) begin
            n_f3.mag[i] = r_f2.mag[i] << sh;
        end
        if (mx == 32'd0 && !r_f2.par && r_f2.status == dr_pkg::ST_OK) begin
            n_f3.status = dr_pkg::ST_ZERO;
        end
    end

    always_comb begin
        n_f4.mag    = r_f3.mag;
        n_f4.neg    = r_f3.neg;
        n_f4.status = r_f3.status;
        n_f4.par    = r_f3.par;
        for (int i = 0; i < 3; i++) begin
            n_f4.sq[i] = 64'(r_f3.mag[i]) * 64'(r_f3.mag[i]);
        end
    end

    always_comb begin
        o_mid.mag    = r_f4.mag;
        o_mid.neg    = r_f4.neg;
        o_mid.status = r_f4.status;
        o_mid.par    = r_f4.par;
        o_mid.sum    = r_f4.sq[0] + r_f4.sq[1] + r_f4.sq[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            r_f3 <= n_f3;
            r_f4 <= n_f4;
        end
    end

endmodule

// ===== sv/dr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dr_queue
// Short queue between the front and the back part.
// ----------------------------------------------------------------------------
module dr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dr_pkg::t_mid  i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dr_pkg::t_mid  o_data
);

    localparam int PW = $clog2(dr_pkg::MID_DEPTH);

    dr_pkg::t_mid  r_mem [dr_pkg::MID_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(dr_pkg::MID_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== sv/dr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dr_back
// Square root and division pipelines, rounding, saturation and result queue.
// ----------------------------------------------------------------------------
module dr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_mid_valid,
    input  dr_pkg::t_mid  i_mid,
    output logic          o_mid_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output dr_pkg::t_out  o_result
);

    localparam int NS = dr_pkg::SQRT_STEPS;
    localparam int ND = dr_pkg::DIV_STEPS;

    typedef struct packed {
        logic [63:0]      rad;
        logic [63:0]      root;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [1:0]       status;
        logic             par;
    } t_sq;

    typedef struct packed {
        logic [31:0]        n;
        logic [2:0][49:0]   rem;
        logic [2:0][ND-1:0] q;
        logic [2:0]         neg;
        logic [1:0]         status;
        logic               par;
    } t_dv;

    logic         en;
    logic [NS:0]  r_vs;
    logic [ND:0]  r_vd;
    t_sq          r_sq [NS+1];
    t_sq          n_sq [NS+1];
    t_dv          r_dv [ND+1];
    t_dv          n_dv [ND+1];
    dr_pkg::t_out n_res;
    dr_pkg::t_out r_of [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         of_push;
    logic         of_pop;

    assign en        = (r_cnt != 2'd2);
    assign o_mid_pop = en && i_mid_valid;
    assign of_push   = en && r_vd[ND];
    assign of_pop    = i_pop && (r_cnt != 2'd0);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_result  = r_of[r_rp];

    always_comb begin
        logic [63:0] bt;
        n_sq[0].rad    = i_mid.sum;
        n_sq[0].root   = '0;
        n_sq[0].mag    = i_mid.mag;
        n_sq[0].neg    = i_mid.neg;
        n_sq[0].status = i_mid.status;
        n_sq[0].par    = i_mid.par;
        for (int i = 0; i < NS; i++) begin
            bt = 64'd1 << (62 - 2 * i);
            n_sq[i+1] = r_sq[i];
            if (r_sq[i].rad >= r_sq[i].root + bt) begin
                n_sq[i+1].rad  = r_sq[i].rad - (r_sq[i].root + bt);
                n_sq[i+1].root = (r_sq[i].root >> 1) + bt;
            end else begin
                n_sq[i+1].root = r_sq[i].root >> 1;
            end
        end
    end

    always_comb begin
        logic [49:0] t;
        n_dv[0].n      = r_sq[NS].root[31:0];
        n_dv[0].q      = '0;
        n_dv[0].neg    = r_sq[NS].neg;
        n_dv[0].status = r_sq[NS].status;
        n_dv[0].par    = r_sq[NS].par;
        for (int k = 0; k < 3; k++) begin
            n_dv[0].rem[k] = {2'b0, r_sq[NS].mag[k], 16'b0};
        end
        for (int j = 0; j < ND; j++) begin
            t = 50'(r_dv[j].n) << (ND - 1 - j);
            n_dv[j+1] = r_dv[j];
            for (int k = 0; k < 3; k++) begin
                if (r_dv[j].rem[k] >= t) begin
                    n_dv[j+1].rem[k]          = r_dv[j].rem[k] - t;
                    n_dv[j+1].q[k][ND-1-j]    = 1'b1;
                end
            end
        end
    end

    always_comb begin
        logic [ND:0]        m;
        logic signed [15:0] r [3];
        for (int k = 0; k < 3; k++) begin
            m = ((ND+1)'(r_dv[ND].q[k]) + 1'b1) >> 1;
            if (r_dv[ND].neg[k]) begin
                if (m > (ND+1)'(32768)) m = (ND+1)'(32768);
                r[k] = 16'(-m);
            end else begin
                if (m > (ND+1)'(32767)) m = (ND+1)'(32767);
                r[k] = 16'(m);
            end
        end
        n_res.status = r_dv[ND].status;
        if (r_dv[ND].status != dr_pkg::ST_OK) begin
            n_res.ray_x = '0;
            n_res.ray_y = '0;
            n_res.ray_z = '0;
        end else if (r_dv[ND].par) begin
            n_res.ray_x = '0;
            n_res.ray_y = '0;
            n_res.ray_z = dr_pkg::RAY_ONE;
        end else begin
            n_res.ray_x = r[0];
            n_res.ray_y = r[1];
            n_res.ray_z = r[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= '0;
            r_vd <= '0;
        end else if (en) begin
            r_vs <= {r_vs[NS-1:0], i_mid_valid};
            r_vd <= {r_vd[ND-1:0], r_vs[NS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i <= NS; i++) r_sq[i] <= n_sq[i];
            for (int j = 0; j <= ND; j++) r_dv[j] <= n_dv[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (of_push) r_wp <= ~r_wp;
            if (of_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(of_push) - 2'(of_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (of_push) r_of[r_wp] <= n_res;
    end

endmodule
